[sv/locd_pkg.sv]
// Shared types and constants of the lock order cycle detector.
package locd_pkg;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_CYCLE   = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_UNKNOWN = 3'd3,
        ST_ORDER   = 3'd4,
        ST_TFULL   = 3'd5,
        ST_SFULL   = 3'd6
    } status_t;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_PEEL,
        S_RESULT,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic start;     // capture the item and clear the lookup scan
        logic scan;      // compare one key table entry
        logic decide;    // apply the item's effect on the stores
        logic peel_init; // load the surviving set for the cycle search
        logic peel;      // one peeling step: examine one node of the graph
        logic finish;    // register the result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic need_search;
        logic peel_done;
    } stat_t;

    localparam int ACTION_ACQUIRE = 0;

endpackage

[sv/locd_ctrl.sv]
// Controller state machine of the lock order cycle detector.
module locd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    output locd_pkg::cmd_t   cmd,
    input  locd_pkg::stat_t  stat
);
    import locd_pkg::*;

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_LOOKUP;
                end
            end
            S_LOOKUP:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (stat.need_search)
                begin
                    cmd.peel_init = 1'b1;
                    state_next    = S_PEEL;
                end
                else
                begin
                    state_next = S_RESULT;
                end
            end
            S_PEEL:
            begin
                cmd.peel = 1'b1;
                if (stat.peel_done)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_RESULT:
            begin
                // The stores have settled; capture the result.
                cmd.finish = 1'b1;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[sv/locd_dp.sv]
// Datapath of the lock order cycle detector: key table, edges, stack, search.
module locd_dp #(
    parameter int MAX_LOCKS   = 16,
    parameter int STACK_DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             action,
    input  logic [31:0]      lock_key,
    input  locd_pkg::cmd_t   cmd,
    output locd_pkg::stat_t  stat,
    output logic [2:0]       status,
    output logic [3:0]       lock_id,
    output logic [4:0]       held_depth
);
    import locd_pkg::*;

    localparam int IW = $clog2(MAX_LOCKS);
    localparam int CW = $clog2(MAX_LOCKS + 1);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    logic [31:0]          key_table [MAX_LOCKS];
    logic [IW-1:0]        held_stack [STACK_DEPTH];
    logic [MAX_LOCKS-1:0] edges_reg [MAX_LOCKS];
    logic [CW-1:0]        known_reg;
    logic [TW-1:0]        top_reg;

    logic                 action_reg;
    logic [31:0]          key_reg;
    logic [31:0]          key_rd_reg;
    logic [CW-1:0]        scan_reg;
    logic                 known_reg_f;
    logic [IW-1:0]        id_reg;
    logic [IW-1:0]        prev_reg;
    logic [MAX_LOCKS-1:0] left_reg;
    logic [MAX_LOCKS-1:0] left_init;
    logic [CW-1:0]        node_reg;
    logic                 changed_reg;
    status_t              st_reg;
    logic [2:0]           status_reg;
    logic [3:0]           lock_id_reg;
    logic [4:0]           depth_reg;

    logic                 scan_hit;
    logic                 stack_full, table_full, has_top, need_edge;
    logic [IW-1:0]        new_id;
    logic [IW-1:0]        node_idx;
    logic                 drop;
    logic                 last_node;

    // Lookup compares one table entry per cycle; the entry was read on the previous edge.
    assign scan_hit = (scan_reg < known_reg) && (key_rd_reg == key_reg);
    assign stat.scan_done = scan_hit || (scan_reg >= known_reg);

    // Decision terms for an acquire.
    assign stack_full = (top_reg >= TW'(STACK_DEPTH));
    assign table_full = !known_reg_f && (known_reg >= CW'(MAX_LOCKS));
    assign has_top    = (top_reg != '0);
    assign new_id     = known_reg_f ? id_reg : known_reg[IW-1:0];
    assign need_edge  = (action_reg == 1'(ACTION_ACQUIRE)) && !stack_full && !table_full
                        && has_top && (prev_reg != new_id) && !edges_reg[prev_reg][new_id];
    assign stat.need_search = need_edge;

    // Peeling walks one node per cycle; a pass without change ends it.
    assign node_idx  = node_reg[IW-1:0];
    assign drop      = left_reg[node_idx] && ((edges_reg[node_idx] & left_reg) == '0);
    assign last_node = (node_reg + CW'(1) >= known_reg);
    assign stat.peel_done = last_node && !(changed_reg || drop);

    // Surviving set at the start of the search: every ID known after this item.
    always_comb
    begin
        left_init = '0;
        for (int i = 0; i < MAX_LOCKS; i++)
        begin
            if (CW'(i) < known_reg + (known_reg_f ? CW'(0) : CW'(1)))
            begin
                left_init[i] = 1'b1;
            end
        end
    end

    // Key table and stack contents are written without reset.
    always_ff @(posedge clk)
    begin
        if (cmd.decide && action_reg == 1'(ACTION_ACQUIRE) && !stack_full && !table_full)
        begin
            if (!known_reg_f)
            begin
                key_table[known_reg[IW-1:0]] <= key_reg;
            end
            held_stack[top_reg[SW-1:0]] <= new_id;
        end
    end

    // Control state and order edges.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            known_reg <= '0;
            top_reg   <= '0;
            for (int i = 0; i < MAX_LOCKS; i++)
            begin
                edges_reg[i] <= '0;
            end
        end
        else if (cmd.decide)
        begin
            if (action_reg == 1'(ACTION_ACQUIRE))
            begin
                if (!stack_full && !table_full)
                begin
                    if (!known_reg_f)
                    begin
                        known_reg <= known_reg + CW'(1);
                    end
                    if (need_edge)
                    begin
                        edges_reg[prev_reg][new_id] <= 1'b1;
                    end
                    top_reg <= top_reg + TW'(1);
                end
            end
            else if (has_top && known_reg_f && prev_reg == id_reg)
            begin
                top_reg <= top_reg - TW'(1);
            end
        end
    end

    // Item working registers.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            action_reg  <= action;
            key_reg     <= lock_key;
            key_rd_reg  <= key_table[0];
            scan_reg    <= '0;
            known_reg_f <= 1'b0;
            id_reg      <= '0;
            prev_reg    <= held_stack[(top_reg == '0) ? '0 : SW'(top_reg - TW'(1))];
        end
        if (cmd.scan)
        begin
            if (scan_hit)
            begin
                known_reg_f <= 1'b1;
                id_reg      <= scan_reg[IW-1:0];
            end
            else if (!stat.scan_done)
            begin
                scan_reg   <= scan_reg + CW'(1);
                key_rd_reg <= key_table[scan_reg[IW-1:0] + IW'(1)];
            end
        end
        if (cmd.decide)
        begin
            if (action_reg == 1'(ACTION_ACQUIRE))
            begin
                if (stack_full)
                begin
                    st_reg <= ST_SFULL;
                end
                else if (table_full)
                begin
                    st_reg <= ST_TFULL;
                    id_reg <= '0;
                end
                else
                begin
                    st_reg <= ST_OK;
                    id_reg <= new_id;
                end
            end
            else if (!has_top)
            begin
                st_reg <= ST_EMPTY;
            end
            else if (!known_reg_f)
            begin
                st_reg <= ST_UNKNOWN;
            end
            else if (prev_reg != id_reg)
            begin
                st_reg <= ST_ORDER;
            end
            else
            begin
                st_reg <= ST_OK;
            end
        end
        if (cmd.peel_init)
        begin
            // The edge and new key land this cycle; the search starts next.
            left_reg    <= left_init;
            node_reg    <= '0;
            changed_reg <= 1'b0;
        end
        if (cmd.peel)
        begin
            if (drop)
            begin
                left_reg[node_idx] <= 1'b0;
            end
            if (last_node)
            begin
                node_reg    <= '0;
                changed_reg <= 1'b0;
            end
            else
            begin
                node_reg    <= node_reg + CW'(1);
                changed_reg <= changed_reg || drop;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            if (cmd.peel && (left_reg & ~(drop ? (MAX_LOCKS'(1) << node_idx) : '0)) != '0)
            begin
                status_reg <= ST_CYCLE;
            end
            else
            begin
                status_reg <= st_reg;
            end
            lock_id_reg <= 4'(id_reg);
            depth_reg   <= 5'(top_reg);
        end
    end

    assign status     = status_reg;
    assign lock_id    = lock_id_reg;
    assign held_depth = depth_reg;

endmodule

[sv/lock_order_cycle_detector_top.sv]
// Top level of the lock order cycle detector.
//
// Each input item acquires (action 0) or releases (action 1) the lock named
// by lock_key. Exactly one result item follows each input item, carrying a
// status code, the dense lock ID and the held-stack depth after the item.
// Both channels use valid and ready handshakes.
//
// One item is processed at a time. The lookup compares the item's key with
// the key table entries one by one up to the match, or with every known key
// for a new key. When a new order edge starts the cycle search, the peeling
// loop then walks the known locks node by node in passes, the last pass
// being one that drops nothing. The serial key compare and the node-by-node
// peeling loop set how long an item takes; a new item is taken in the cycle
// after the previous result has been accepted.
//
// Reset clears the key count, the stack depth and all order edges; the
// block is ready for an item as soon as reset is released. A stalled receiver
// holds the result and the block takes no new item until it is accepted.
module lock_order_cycle_detector_top #(
    parameter int MAX_LOCKS   = 16,
    parameter int STACK_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        action,
    input  logic [31:0] lock_key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [3:0]  lock_id,
    output logic [4:0]  held_depth
);
    import locd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    // Sequencer.
    locd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    // Stores and search.
    locd_dp #(
        .MAX_LOCKS   (MAX_LOCKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .action     (action),
        .lock_key   (lock_key),
        .cmd        (cmd),
        .stat       (stat),
        .status     (status),
        .lock_id    (lock_id),
        .held_depth (held_depth)
    );

endmodule

[sv/locd_checker.sv]
// Port-level checker for the lock order cycle detector, bound to the top level.
module locd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic [4:0] held_depth
);
    import locd_pkg::*;

    // A result stays offered until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped while stalled");

    // No input is taken while a result is pending.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input taken while result pending");

    // Status is always a defined code.
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= ST_SFULL)
        else $error("undefined status");

    // An empty stack release reports depth zero.
    a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> held_depth == 5'd0)
        else $error("empty status with nonzero depth");

endmodule

bind lock_order_cycle_detector_top locd_checker u_locd_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .held_depth (held_depth)
);
